>>> src/keyboard_map_tuning_deviation_unit_assert.svh
// assertion macros for the keyboard map tuning deviation unit
// included by the modules that check their own pipeline invariants
`ifndef KEYBOARD_MAP_TUNING_DEVIATION_UNIT_ASSERT_SVH
`define KEYBOARD_MAP_TUNING_DEVIATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define KMTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// condition holds in the cycle after the trigger
`define KMTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KMTD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define KMTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/kmtd_pkg.sv
// shared types, codes and constants of the keyboard map tuning deviation unit
// no dependencies; used by kmtd_div_pipe and the top module, not by kmtd_ram
package kmtd_pkg;

   localparam int NOTE_W    = 7;
   localparam int CENTS_W   = 32;
   localparam int DIV_STEPS = NOTE_W;

   // pitch of the 12-tet reference note and one semitone in q16.16 cents
   localparam logic [7:0]         A4_NOTE  = 8'd69;
   localparam logic signed [23:0] SEMI_Q16 = 24'sd6553600;

   // request codes
   typedef enum logic [1:0] {
      REQ_WRITE_DEGREE = 2'd0,
      REQ_WRITE_MAP    = 2'd1,
      REQ_LOOKUP       = 2'd2
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SCALE_SIZE  = 3'd0,
      CSR_MAP_SIZE    = 3'd1,
      CSR_MAP_LENGTH  = 3'd2,
      CSR_MIDDLE_NOTE = 3'd3,
      CSR_REF_NOTE    = 3'd4,
      CSR_REF_OFFSET  = 3'd5
   } csr_index_type;

   // one accepted request as it moves down the pipeline
   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         position;
      logic signed [31:0] cents;
      logic signed [7:0]  degree;
      logic [6:0]         note;
   } req_item_type;

   // state of one restoring division lane
   typedef struct packed {
      logic       neg;
      logic [6:0] mag;
      logic [7:0] rem;
      logic [6:0] quo;
   } div_lane_type;

   // period number and map position of one key
   typedef struct packed {
      logic signed [7:0] per;
      logic [7:0]        pos;
   } key_pos_type;

   // resolved degree of one key
   typedef struct packed {
      logic              unmapped;
      logic              zero;
      logic signed [7:0] per;
      logic [7:0]        index;
   } key_deg_type;

   // one quotient bit of a restoring division
   function automatic div_lane_type div_step(div_lane_type lane, logic [7:0] divisor);
      logic [8:0]   partial;
      logic [8:0]   diff;
      div_lane_type nxt;
      partial  = {lane.rem, lane.mag[NOTE_W-1]};
      diff     = partial - {1'b0, divisor};
      nxt      = lane;
      nxt.mag  = {lane.mag[NOTE_W-2:0], 1'b0};
      if (partial >= {1'b0, divisor}) begin
         nxt.rem = diff[7:0];
         nxt.quo = {lane.quo[NOTE_W-2:0], 1'b1};
      end else begin
         nxt.rem = partial[7:0];
         nxt.quo = {lane.quo[NOTE_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

>>> src/kmtd_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module kmtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/kmtd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
// depends on kmtd_pkg; carries the request item alongside the lanes
`include "keyboard_map_tuning_deviation_unit_assert.svh"
module kmtd_div_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic [7:0]             divisor,
   input  logic                   in_valid,
   input  kmtd_pkg::req_item_type in_item,
   input  kmtd_pkg::div_lane_type in_lane_n,
   input  kmtd_pkg::div_lane_type in_lane_r,
   output logic                   out_valid,
   output kmtd_pkg::req_item_type out_item,
   output kmtd_pkg::div_lane_type out_lane_n,
   output kmtd_pkg::div_lane_type out_lane_r
);

   localparam int STEPS = kmtd_pkg::DIV_STEPS;

   logic [STEPS-1:0]       valid_ff;
   logic [STEPS-1:0]       valid_in;
   kmtd_pkg::req_item_type item_ff   [STEPS];
   kmtd_pkg::req_item_type item_in   [STEPS];
   kmtd_pkg::div_lane_type lane_n_ff [STEPS];
   kmtd_pkg::div_lane_type lane_n_in [STEPS];
   kmtd_pkg::div_lane_type lane_r_ff [STEPS];
   kmtd_pkg::div_lane_type lane_r_in [STEPS];

   // each stage takes one step on what the stage before it holds
   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            valid_in[k]  = in_valid;
            item_in[k]   = in_item;
            lane_n_in[k] = kmtd_pkg::div_step(in_lane_n, divisor);
            lane_r_in[k] = kmtd_pkg::div_step(in_lane_r, divisor);
         end else begin
            valid_in[k]  = valid_ff[k-1];
            item_in[k]   = item_ff[k-1];
            lane_n_in[k] = kmtd_pkg::div_step(lane_n_ff[k-1], divisor);
            lane_r_in[k] = kmtd_pkg::div_step(lane_r_ff[k-1], divisor);
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff   <= item_in;
         lane_n_ff <= lane_n_in;
         lane_r_ff <= lane_r_in;
      end
   end

   assign out_valid  = valid_ff[STEPS-1];
   assign out_item   = item_ff[STEPS-1];
   assign out_lane_n = lane_n_ff[STEPS-1];
   assign out_lane_r = lane_r_ff[STEPS-1];

   // remainders stay below the divisor for lookups
   `KMTD_ASSERT_SAME(a_rem_note_bound, clock, reset, out_valid && out_item.kind == kmtd_pkg::REQ_LOOKUP && divisor != 8'd0, out_lane_n.rem < divisor, "note remainder not below divisor")
   `KMTD_ASSERT_SAME(a_rem_ref_bound, clock, reset, out_valid && out_item.kind == kmtd_pkg::REQ_LOOKUP && divisor != 8'd0, out_lane_r.rem < divisor, "reference remainder not below divisor")
   // a frozen pipeline keeps its last stage
   `KMTD_ASSERT_NEXT(a_frozen_hold, clock, reset, !enable, $stable(out_valid), "divider advanced while frozen")

endmodule

>>> src/keyboard_map_tuning_deviation_unit.sv
// Keyboard map tuning deviation unit: returns a note's deviation from 12-tet in q16.16
// cents from a scale degree table and a keyboard mapping table held in on-chip ram.
// One request is accepted every cycle while req_stall is low. Table writes produce no
// result; each lookup gives one result, passing through the input register, seven
// divider stages of one quotient bit each for the floor division by the map size, the
// mapping ram read, degree ram read, period multiply and final sum, and the output
// register. Writes take effect at the ram stage in request order, so a lookup always
// sees exactly the writes accepted before it. A result held at the output by rsp_stall
// freezes the pipeline only once the next lookup reaches the final stage. Tables come
// up undefined; no clearing pass runs after reset. The user writes configuration only
// while no request is in flight; the block itself does not enforce this.
// depends on kmtd_pkg, kmtd_ram, kmtd_div_pipe
`include "keyboard_map_tuning_deviation_unit_assert.svh"
module keyboard_map_tuning_deviation_unit #(
   parameter int MAX_SCALE_DEGREES = 128,
   parameter int MAX_MAP_ENTRIES   = 128
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [6:0]         req_table_position,
   input  logic signed [31:0] req_cents_value,
   input  logic signed [7:0]  req_map_degree,
   input  logic [6:0]         req_note_number,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_deviation_cents,
   output logic               rsp_note_unmapped,
   output logic [6:0]         rsp_note_echo,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int DEG_AW = (MAX_SCALE_DEGREES > 1) ? $clog2(MAX_SCALE_DEGREES) : 1;
   localparam int MAP_AW = (MAX_MAP_ENTRIES > 1) ? $clog2(MAX_MAP_ENTRIES) : 1;
   localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
   localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

   // configuration registers
   logic [7:0]         scale_size_ff;
   logic [7:0]         map_size_ff;
   logic [7:0]         map_length_ff;
   logic [6:0]         middle_note_ff;
   logic [6:0]         ref_note_ff;
   logic signed [31:0] ref_offset_ff;

   // derived sizes
   logic [10:0] scale_wide;
   logic [10:0] length_wide;
   logic [7:0]  sz;
   logic [7:0]  msz;
   logic [7:0]  mlen;

   logic adv;

   // input stage
   logic                   p0_valid_ff;
   kmtd_pkg::req_item_type p0_item_ff;
   kmtd_pkg::req_item_type p0_item_in;
   logic [7:0]             rel_n;
   logic [7:0]             rel_r;
   logic [7:0]             neg_rel_n;
   logic [7:0]             neg_rel_r;
   kmtd_pkg::div_lane_type lane_n_init;
   kmtd_pkg::div_lane_type lane_r_init;

   // divider output
   logic                   div_valid;
   kmtd_pkg::req_item_type div_item;
   kmtd_pkg::div_lane_type div_lane_n;
   kmtd_pkg::div_lane_type div_lane_r;
   kmtd_pkg::key_pos_type  kp_n;
   kmtd_pkg::key_pos_type  kp_r;
   logic                   inr_n;
   logic                   inr_r;
   logic [10:0]            tpos_wide;
   logic [10:0]            map_pos_n_wide;
   logic [10:0]            map_pos_r_wide;
   logic                   map_wr_en;

   // mapping read stage
   logic                   m_valid_ff;
   kmtd_pkg::req_item_type m_item_ff;
   logic signed [7:0]      m_per_n_ff;
   logic signed [7:0]      m_per_r_ff;
   logic                   m_inr_n_ff;
   logic                   m_inr_r_ff;
   logic [7:0]             map_n_q;
   logic [7:0]             map_r_q;
   kmtd_pkg::key_deg_type  kd_n;
   kmtd_pkg::key_deg_type  kd_r;
   logic [10:0]            m_tpos_wide;
   logic [10:0]            deg_idx_n_wide;
   logic [10:0]            deg_idx_r_wide;
   logic [10:0]            period_wide;
   logic [7:0]             period_idx;
   logic                   deg_wr_en;
   logic signed [8:0]      dper_in;

   // degree read stage
   logic                   c_valid_ff;
   kmtd_pkg::req_item_type c_item_ff;
   logic signed [8:0]      c_dper_ff;
   logic                   c_zero_n_ff;
   logic                   c_zero_r_ff;
   logic                   c_unmapped_ff;
   logic [31:0]            deg_n_q;
   logic [31:0]            deg_r_q;
   logic [31:0]            period_q;
   logic signed [31:0]     base_n;
   logic signed [31:0]     base_r;
   logic signed [31:0]     period_s;
   logic signed [7:0]      note_off;
   logic signed [31:0]     semi_term;
   logic signed [40:0]     prod_in;
   logic signed [32:0]     basediff_in;
   logic signed [33:0]     k_in;

   // sum stage
   logic                   x_valid_ff;
   kmtd_pkg::req_item_type x_item_ff;
   logic signed [40:0]     x_prod_ff;
   logic signed [32:0]     x_basediff_ff;
   logic signed [33:0]     x_k_ff;
   logic                   x_unmapped_ff;
   logic                   x_is_result;
   logic signed [41:0]     x_sum;
   logic signed [31:0]     x_sat;
   logic signed [31:0]     dev_in;
   logic                   unmapped_in;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic signed [31:0]     rsp_dev_ff;
   logic                   rsp_unmapped_ff;
   logic [6:0]             rsp_note_ff;

   // floor division fixup: period number and map position
   function automatic kmtd_pkg::key_pos_type floor_fix(kmtd_pkg::div_lane_type lane,
                                                       logic [7:0] divisor);
      kmtd_pkg::key_pos_type kp;
      kp.per = $signed({1'b0, lane.quo});
      kp.pos = lane.rem;
      if (lane.neg && lane.rem != 8'd0) begin
         kp.per = $signed(8'd0 - ({1'b0, lane.quo} + 8'd1));
         kp.pos = divisor - lane.rem;
      end else if (lane.neg) begin
         kp.per = $signed(8'd0 - {1'b0, lane.quo});
         kp.pos = 8'd0;
      end
      return kp;
   endfunction

   // mapping entry to clamped degree; keys past the map length count as zero cents
   function automatic kmtd_pkg::key_deg_type resolve(logic [7:0] entry, logic inr,
                                                     logic signed [7:0] per,
                                                     logic [7:0] size);
      kmtd_pkg::key_deg_type kd;
      logic [7:0]            degc;
      degc        = (entry > size) ? size : entry;
      kd.unmapped = inr && entry[7];
      kd.zero     = !inr || entry[7] || degc == 8'd0;
      kd.per      = inr ? per : 8'sd0;
      kd.index    = degc - 8'd1;
      return kd;
   endfunction

   // ---------------------------------------------------------------------------------
   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_size_ff  <= 8'd12;
         map_size_ff    <= 8'd0;
         map_length_ff  <= 8'd12;
         middle_note_ff <= 7'd60;
         ref_note_ff    <= 7'd69;
         ref_offset_ff  <= 32'sd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kmtd_pkg::CSR_SCALE_SIZE:  scale_size_ff  <= csr_wdata[7:0];
            kmtd_pkg::CSR_MAP_SIZE:    map_size_ff    <= csr_wdata[7:0];
            kmtd_pkg::CSR_MAP_LENGTH:  map_length_ff  <= csr_wdata[7:0];
            kmtd_pkg::CSR_MIDDLE_NOTE: middle_note_ff <= csr_wdata[6:0];
            kmtd_pkg::CSR_REF_NOTE:    ref_note_ff    <= csr_wdata[6:0];
            kmtd_pkg::CSR_REF_OFFSET:  ref_offset_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // scale size and map length clamped to the table depths; a zero map size means the scale size
   always_comb begin
      scale_wide  = {3'b0, scale_size_ff};
      length_wide = {3'b0, map_length_ff};
      sz   = (scale_wide > 11'(MAX_SCALE_DEGREES)) ?
             8'(MAX_SCALE_DEGREES) : scale_size_ff;
      mlen = (length_wide > 11'(MAX_MAP_ENTRIES)) ?
             8'(MAX_MAP_ENTRIES) : map_length_ff;
      msz  = (map_size_ff != 8'd0) ? map_size_ff : sz;
   end

   // ---------------------------------------------------------------------------------
   // pipeline advance: only a lookup blocked at a full, stalled output freezes it
   assign x_is_result = x_valid_ff && x_item_ff.kind == kmtd_pkg::REQ_LOOKUP;
   assign adv         = !(rsp_valid_ff && rsp_stall && x_is_result);
   assign req_stall   = !adv;

   // input register
   always_comb begin
      p0_item_in.kind     = req_type;
      p0_item_in.position = req_table_position;
      p0_item_in.cents    = req_cents_value;
      p0_item_in.degree   = req_map_degree;
      p0_item_in.note     = req_note_number;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_item_ff <= p0_item_in;
      end
   end

   // key offsets from the middle note, split into sign and magnitude
   always_comb begin
      rel_n     = {1'b0, p0_item_ff.note} - {1'b0, middle_note_ff};
      rel_r     = {1'b0, ref_note_ff} - {1'b0, middle_note_ff};
      neg_rel_n = 8'd0 - rel_n;
      neg_rel_r = 8'd0 - rel_r;
      lane_n_init.neg = rel_n[7];
      lane_n_init.mag = rel_n[7] ? neg_rel_n[6:0] : rel_n[6:0];
      lane_n_init.rem = 8'd0;
      lane_n_init.quo = 7'd0;
      lane_r_init.neg = rel_r[7];
      lane_r_init.mag = rel_r[7] ? neg_rel_r[6:0] : rel_r[6:0];
      lane_r_init.rem = 8'd0;
      lane_r_init.quo = 7'd0;
   end

   kmtd_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .divisor    (msz),
      .in_valid   (p0_valid_ff),
      .in_item    (p0_item_ff),
      .in_lane_n  (lane_n_init),
      .in_lane_r  (lane_r_init),
      .out_valid  (div_valid),
      .out_item   (div_item),
      .out_lane_n (div_lane_n),
      .out_lane_r (div_lane_r)
   );

   // ---------------------------------------------------------------------------------
   // map position, mapping ram access and mapping writes
   always_comb begin
      kp_n           = floor_fix(div_lane_n, msz);
      kp_r           = floor_fix(div_lane_r, msz);
      inr_n          = kp_n.pos < mlen;
      inr_r          = kp_r.pos < mlen;
      map_pos_n_wide = {3'b0, kp_n.pos};
      map_pos_r_wide = {3'b0, kp_r.pos};
      tpos_wide      = {4'b0, div_item.position};
      map_wr_en      = adv && div_valid && div_item.kind == kmtd_pkg::REQ_WRITE_MAP &&
                       tpos_wide < 11'(MAX_MAP_ENTRIES);
   end

   kmtd_ram #(.WIDTH(8), .DEPTH(MAX_MAP_ENTRIES)) u_map_note (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (tpos_wide[MAP_AW-1:0]),
      .wr_data (div_item.degree),
      .rd_en   (adv),
      .rd_addr (map_pos_n_wide[MAP_AW-1:0]),
      .rd_data (map_n_q)
   );

   kmtd_ram #(.WIDTH(8), .DEPTH(MAX_MAP_ENTRIES)) u_map_ref (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (tpos_wide[MAP_AW-1:0]),
      .wr_data (div_item.degree),
      .rd_en   (adv),
      .rd_addr (map_pos_r_wide[MAP_AW-1:0]),
      .rd_data (map_r_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_item_ff  <= div_item;
         m_per_n_ff <= kp_n.per;
         m_per_r_ff <= kp_r.per;
         m_inr_n_ff <= inr_n;
         m_inr_r_ff <= inr_r;
      end
   end

   // ---------------------------------------------------------------------------------
   // degree resolve, degree ram access and degree writes
   always_comb begin
      kd_n           = resolve(map_n_q, m_inr_n_ff, m_per_n_ff, sz);
      kd_r           = resolve(map_r_q, m_inr_r_ff, m_per_r_ff, sz);
      deg_idx_n_wide = {3'b0, kd_n.index};
      deg_idx_r_wide = {3'b0, kd_r.index};
      period_idx     = sz - 8'd1;
      period_wide    = {3'b0, period_idx};
      m_tpos_wide    = {4'b0, m_item_ff.position};
      deg_wr_en      = adv && m_valid_ff && m_item_ff.kind == kmtd_pkg::REQ_WRITE_DEGREE &&
                       m_tpos_wide < 11'(MAX_SCALE_DEGREES);
      dper_in        = {kd_n.per[7], kd_n.per} - {kd_r.per[7], kd_r.per};
   end

   kmtd_ram #(.WIDTH(32), .DEPTH(MAX_SCALE_DEGREES)) u_deg_note (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (m_tpos_wide[DEG_AW-1:0]),
      .wr_data (m_item_ff.cents),
      .rd_en   (adv),
      .rd_addr (deg_idx_n_wide[DEG_AW-1:0]),
      .rd_data (deg_n_q)
   );

   kmtd_ram #(.WIDTH(32), .DEPTH(MAX_SCALE_DEGREES)) u_deg_ref (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (m_tpos_wide[DEG_AW-1:0]),
      .wr_data (m_item_ff.cents),
      .rd_en   (adv),
      .rd_addr (deg_idx_r_wide[DEG_AW-1:0]),
      .rd_data (deg_r_q)
   );

   kmtd_ram #(.WIDTH(32), .DEPTH(MAX_SCALE_DEGREES)) u_deg_period (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (m_tpos_wide[DEG_AW-1:0]),
      .wr_data (m_item_ff.cents),
      .rd_en   (adv),
      .rd_addr (period_wide[DEG_AW-1:0]),
      .rd_data (period_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_item_ff     <= m_item_ff;
         c_dper_ff     <= dper_in;
         c_zero_n_ff   <= kd_n.zero;
         c_zero_r_ff   <= kd_r.zero;
         c_unmapped_ff <= kd_n.unmapped || kd_r.unmapped;
      end
   end

   // ---------------------------------------------------------------------------------
   // period shift, pitch difference and the 12-tet term
   always_comb begin
      base_n      = c_zero_n_ff ? 32'sd0 : $signed(deg_n_q);
      base_r      = c_zero_r_ff ? 32'sd0 : $signed(deg_r_q);
      period_s    = $signed(period_q);
      prod_in     = c_dper_ff * period_s;
      basediff_in = {base_n[31], base_n} - {base_r[31], base_r};
      note_off    = $signed({1'b0, c_item_ff.note} - kmtd_pkg::A4_NOTE);
      semi_term   = note_off * kmtd_pkg::SEMI_Q16;
      k_in        = {{2{ref_offset_ff[31]}}, ref_offset_ff} -
                    {{2{semi_term[31]}}, semi_term};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (adv) begin
         x_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_item_ff     <= c_item_ff;
         x_prod_ff     <= prod_in;
         x_basediff_ff <= basediff_in;
         x_k_ff        <= k_in;
         x_unmapped_ff <= c_unmapped_ff;
      end
   end

   // final sum and saturation
   always_comb begin
      x_sum = {x_prod_ff[40], x_prod_ff} +
              {{9{x_basediff_ff[32]}}, x_basediff_ff} +
              {{8{x_k_ff[33]}}, x_k_ff};
      if (x_sum > SAT_MAX) begin
         x_sat = 32'sh7FFFFFFF;
      end else if (x_sum < SAT_MIN) begin
         x_sat = 32'sh80000000;
      end else begin
         x_sat = x_sum[31:0];
      end
      unmapped_in = (sz != 8'd0) && x_unmapped_ff;
      dev_in      = (sz == 8'd0 || x_unmapped_ff) ? 32'sd0 : x_sat;
   end

   // ---------------------------------------------------------------------------------
   // output register
   always_comb begin
      if (x_is_result && adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_is_result && adv) begin
         rsp_dev_ff      <= dev_in;
         rsp_unmapped_ff <= unmapped_in;
         rsp_note_ff     <= x_item_ff.note;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_deviation_cents = rsp_dev_ff;
   assign rsp_note_unmapped   = rsp_unmapped_ff;
   assign rsp_note_echo       = rsp_note_ff;

   // a lookup leaving the last stage lands in the output register
   `KMTD_ASSERT_NEXT(a_result_loads, clock, reset, x_is_result && !req_stall, rsp_valid, "lookup lost at output")
   // unmapped keys report zero deviation
   `KMTD_ASSERT_SAME(a_unmapped_zero, clock, reset, rsp_valid && rsp_note_unmapped, rsp_deviation_cents == 32'sd0, "unmapped result with nonzero deviation")
   // table writes never make a result
   `KMTD_ASSERT_NEXT(a_write_silent, clock, reset, x_valid_ff && x_item_ff.kind != kmtd_pkg::REQ_LOOKUP && !rsp_stall, !rsp_valid, "write produced a result")

endmodule
